### hw/rtl/frml_pkg.sv
// ----------------------------------------------------------------------------
// frml_pkg
// Shared types and constants of the frame rate meter and limiter.
// ----------------------------------------------------------------------------
package frml_pkg;

  localparam int unsigned TS_W        = 32;
  localparam int unsigned FT_W        = 16;
  localparam int unsigned FPS_W       = 18;
  localparam int unsigned DELAY_W     = 10;
  localparam int unsigned CAP_W       = 10;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  localparam logic [FPS_W-1:0]   FPS_DEFAULT_Q8 = 18'd15360;
  localparam logic [FPS_W-1:0]   FPS_MAX_Q8     = 18'd256000;
  localparam int unsigned        FPS_SCALE      = 256000;
  localparam int unsigned        PERIOD_NUM     = 1000;
  localparam int unsigned        PERIOD_NUM_W   = 10;
  localparam logic [CAP_W-1:0]   MAX_FPS_RESET  = 10'd60;
  localparam logic [FT_W-1:0]    FT_SAT         = 16'hFFFF;

  // event kinds
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_END   = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_MAX_FPS = 1'b0;

  typedef struct packed {
    logic capture;
    logic ring_update;
    logic div_period_start;
    logic delay_store;
    logic div_fps_start;
    logic fps_default;
    logic fps_store;
    logic load_out;
  } frml_cmd_t;

  typedef struct packed {
    logic in_is_end;
    logic total_zero;
    logic div_done;
  } frml_sts_t;

endpackage

### hw/rtl/frml_ram.sv
// ----------------------------------------------------------------------------
// frml_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module frml_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 10,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/frml_div.sv
// ----------------------------------------------------------------------------
// frml_div
// Restoring divider, one quotient bit per cycle, run for a given bit count.
// ----------------------------------------------------------------------------
module frml_div #(
  parameter int unsigned DW    = 22,
  parameter int unsigned VW    = 20,
  parameter int unsigned CNT_W = $clog2(DW + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DW-1:0]    dividend_i,
  input  logic [VW-1:0]    divisor_i,
  input  logic [CNT_W-1:0] iters_i,
  output logic             done_o,
  output logic [DW-1:0]    quot_o
);

  logic [DW-1:0]    quot_q;
  logic [VW:0]      rem_q;
  logic [VW-1:0]    dvsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [VW:0]      rem_shift;
  logic [VW+1:0]    trial;

  assign rem_shift = {rem_q[VW-1:0], quot_q[DW-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, dvsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iters_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[VW+1]) begin
        rem_q  <= trial[VW:0];
        quot_q <= {quot_q[DW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_shift;
        quot_q <= {quot_q[DW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### hw/rtl/frml_dpath.sv
// ----------------------------------------------------------------------------
// frml_dpath
// Datapath: timestamps, frame time ring, running total, divider and results.
// ----------------------------------------------------------------------------
module frml_dpath #(
  parameter int unsigned WINDOW_SIZE = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  frml_pkg::frml_cmd_t               cmd_i,
  output frml_pkg::frml_sts_t               sts_o,
  input  logic [frml_pkg::CAP_W-1:0]        max_fps_i,
  input  logic                              action_i,
  input  logic [frml_pkg::TS_W-1:0]         timestamp_i,
  output logic [frml_pkg::FT_W-1:0]         frame_time_o,
  output logic [frml_pkg::FPS_W-1:0]        fps_o,
  output logic [frml_pkg::DELAY_W-1:0]      delay_o
);
  import frml_pkg::*;

  localparam int unsigned SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned TOT_W  = $clog2(WINDOW_SIZE * 65535 + 1);
  localparam int unsigned NUM_W  = $clog2(FPS_SCALE * WINDOW_SIZE + 1);
  localparam int unsigned VW     = (TOT_W > CAP_W) ? TOT_W : CAP_W;
  localparam int unsigned CNT_W  = $clog2(NUM_W + 1);

  logic [TS_W-1:0]    start_q;
  logic [TS_W-1:0]    prev_q;
  logic               have_prev_q;
  logic [TS_W-1:0]    now_q;
  logic [FT_W-1:0]    delta_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [FILL_W-1:0]  filled_q;
  logic [TOT_W-1:0]   total_q;
  logic [FPS_W-1:0]   fps_q;
  logic [DELAY_W-1:0] delay_q;
  logic [FT_W-1:0]    out_ft_q;
  logic [FPS_W-1:0]   out_fps_q;
  logic [DELAY_W-1:0] out_delay_q;

  logic [TS_W-1:0]    diff;
  logic [FT_W-1:0]    delta_d;
  logic               full;
  logic [FT_W-1:0]    ring_rdata;
  logic [TOT_W-1:0]   total_d;
  logic [CAP_W-1:0]   cap;
  logic               div_start;
  logic [NUM_W-1:0]   div_dividend;
  logic [VW-1:0]      div_divisor;
  logic [CNT_W-1:0]   div_iters;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;
  logic [CAP_W-1:0]   period;
  logic [TS_W-1:0]    elapsed;

  assign diff    = timestamp_i - prev_q;
  assign delta_d = !have_prev_q ? '0 : ((|diff[TS_W-1:FT_W]) ? FT_SAT : diff[FT_W-1:0]);
  assign full    = (filled_q == FILL_W'(WINDOW_SIZE));
  assign total_d = total_q - (full ? TOT_W'(ring_rdata) : '0) + TOT_W'(delta_q);
  assign cap     = (max_fps_i == '0) ? CAP_W'(1) : max_fps_i;
  assign period  = div_quot[CAP_W-1:0];
  assign elapsed = now_q - start_q;

  frml_ram #(
    .WIDTH (FT_W),
    .DEPTH (WINDOW_SIZE),
    .AW    (SLOT_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ring_update),
    .waddr_i (slot_q),
    .wdata_i (delta_q),
    .re_i    (cmd_i.capture),
    .raddr_i (slot_q),
    .rdata_o (ring_rdata)
  );

  always_comb begin
    div_start    = cmd_i.div_period_start | cmd_i.div_fps_start;
    div_dividend = NUM_W'(FPS_SCALE) * NUM_W'(filled_q);
    div_divisor  = VW'(total_q);
    div_iters    = CNT_W'(NUM_W);
    if (cmd_i.div_period_start) begin
      div_dividend = NUM_W'(PERIOD_NUM) << (NUM_W - PERIOD_NUM_W);
      div_divisor  = VW'(cap);
      div_iters    = CNT_W'(PERIOD_NUM_W);
    end
  end

  frml_div #(
    .DW    (NUM_W),
    .VW    (VW),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .iters_i    (div_iters),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      slot_q      <= '0;
      filled_q    <= '0;
      total_q     <= '0;
    end else begin
      if (cmd_i.capture) begin
        if (action_i == ACT_BEGIN) begin
          start_q <= timestamp_i;
        end else begin
          prev_q      <= timestamp_i;
          have_prev_q <= 1'b1;
        end
      end
      if (cmd_i.ring_update) begin
        total_q <= total_d;
        if (!full) begin
          filled_q <= filled_q + FILL_W'(1);
        end
        slot_q <= (slot_q == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot_q + SLOT_W'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && action_i == ACT_END) begin
      now_q   <= timestamp_i;
      delta_q <= delta_d;
    end
    if (cmd_i.delay_store) begin
      delay_q <= (elapsed < TS_W'(period)) ? DELAY_W'(period - elapsed[CAP_W-1:0]) : '0;
    end
    if (cmd_i.fps_default) begin
      fps_q <= FPS_DEFAULT_Q8;
    end else if (cmd_i.fps_store) begin
      fps_q <= (div_quot > NUM_W'(FPS_MAX_Q8)) ? FPS_MAX_Q8 : div_quot[FPS_W-1:0];
    end
    if (cmd_i.load_out) begin
      out_ft_q    <= delta_q;
      out_fps_q   <= fps_q;
      out_delay_q <= delay_q;
    end
  end

  assign sts_o.in_is_end  = (action_i == ACT_END);
  assign sts_o.total_zero = (total_q == '0);
  assign sts_o.div_done   = div_done;

  assign frame_time_o = out_ft_q;
  assign fps_o        = out_fps_q;
  assign delay_o      = out_delay_q;

endmodule

### hw/rtl/frml_ctrl.sv
// ----------------------------------------------------------------------------
// frml_ctrl
// Controller: sequences ring update, the period division, the frame rate division
// unless the window total is zero, and the result stage.
module frml_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  input  frml_pkg::frml_sts_t sts_i,
  output frml_pkg::frml_cmd_t cmd_o
);
  import frml_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV_PERIOD,
    ST_DIV_FPS,
    ST_OUTPUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign accept   = s_tvalid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    cmd_o                  = '0;
    cmd_o.capture          = accept;
    cmd_o.ring_update      = (state_q == ST_UPDATE);
    cmd_o.div_period_start = (state_q == ST_UPDATE);
    if (state_q == ST_DIV_PERIOD && sts_i.div_done) begin
      cmd_o.delay_store   = 1'b1;
      cmd_o.fps_default   = sts_i.total_zero;
      cmd_o.div_fps_start = !sts_i.total_zero;
    end
    cmd_o.fps_store = (state_q == ST_DIV_FPS) && sts_i.div_done;
    cmd_o.load_out  = (state_q == ST_OUTPUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && sts_i.in_is_end) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state_q <= ST_DIV_PERIOD;
        end
        ST_DIV_PERIOD: begin
          if (sts_i.div_done) begin
            state_q <= sts_i.total_zero ? ST_OUTPUT : ST_DIV_FPS;
          end
        end
        ST_DIV_FPS: begin
          if (sts_i.div_done) begin
            state_q <= ST_OUTPUT;
          end
        end
        ST_OUTPUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_valid_q;

endmodule

### hw/rtl/frame_rate_meter_limiter_unit.sv
// ----------------------------------------------------------------------------
// frame_rate_meter_limiter_unit
// Frame rate meter over a ring of recent frame times, with a limiter delay.
// ----------------------------------------------------------------------------
// begin event: taken with no result
// end event: result passes through ST_UPDATE, ST_DIV_PERIOD, ST_DIV_FPS and ST_OUTPUT,
//   skipping ST_DIV_FPS when the window total is zero; the bit-serial divider runs for the
//   period and then the frame rate; a stalled output register adds its wait
// one event at a time; the next is taken while a result waits
// rst_ni clears all control state and sets max_fps to 60; ring contents need no reset
module frame_rate_meter_limiter_unit #(
  parameter int unsigned WINDOW_SIZE = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [frml_pkg::TS_W-1:0]           s_axis_tdata,  // timestamp_ms
  input  logic                                s_axis_tuser,  // action
  // result out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [frml_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // frame_time_ms, fps_q8, delay_ms
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [frml_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [frml_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [frml_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import frml_pkg::*;

  logic [CAP_W-1:0]   max_fps_q;
  frml_cmd_t          cmd;
  frml_sts_t          sts;
  logic [FT_W-1:0]    frame_time;
  logic [FPS_W-1:0]   fps;
  logic [DELAY_W-1:0] delay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fps_q <= MAX_FPS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MAX_FPS) begin
      max_fps_q <= pwdata[CAP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_FPS) ? APB_DATA_W'(max_fps_q) : '0;

  frml_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  frml_dpath #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .max_fps_i    (max_fps_q),
    .action_i     (s_axis_tuser),
    .timestamp_i  (s_axis_tdata),
    .frame_time_o (frame_time),
    .fps_o        (fps),
    .delay_o      (delay)
  );

  assign m_axis_tdata = {4'b0000, delay, fps, frame_time};

endmodule

### hw/rtl/frml_checker.sv
// ----------------------------------------------------------------------------
// frml_checker
// Port-level checks of the frame rate meter and limiter, bound to the top.
// ----------------------------------------------------------------------------
module frml_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                s_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [frml_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import frml_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // frame rate stays within its saturation limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:16] <= FPS_MAX_Q8)
    else $error("fps_q8 above limit");

  // an end event occupies the block for the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_END |=> !s_axis_tready)
    else $error("end event not held");

  // a begin event with nothing pending gives no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_BEGIN && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("result from begin event");

endmodule

bind frame_rate_meter_limiter_unit frml_checker u_frml_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/frame_rate_meter_limiter_unit_tb.sv
// ----------------------------------------------------------------------------
// frame_rate_meter_limiter_unit_tb
// Drives begin and end frame events with millisecond timestamps into the
// frame rate meter and limiter, and changes the rate cap over the APB port
// between phases. A predictor keeps its own copy of the frame time ring, the
// running total and the cap, and works out frame time, average rate and
// limiter delay for each end event. Results are checked field by field, in
// order; both stream sides idle at random in the first two random phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_rate_meter_limiter_unit_tb;
  import frml_pkg::*;

  localparam int unsigned WINDOW     = 10;
  localparam int unsigned SETTLE_CYC = 64;

  typedef struct packed {
    logic [FT_W-1:0]    frame_time;
    logic [FPS_W-1:0]   fps;
    logic [DELAY_W-1:0] delay;
  } frame_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TS_W-1:0]       s_axis_tdata = '0;
  logic                  s_axis_tuser = ACT_BEGIN;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor state
  logic [CAP_W-1:0]  cap_reg;
  logic [TS_W-1:0]   frame_start;
  logic [TS_W-1:0]   last_end;
  logic              seen_end;
  logic [FT_W-1:0]   frame_ring [WINDOW];
  int unsigned       ring_slot;
  int unsigned       ring_count;
  int unsigned       ring_total;

  frame_result_t     pending_results [$];
  int unsigned       err_cnt = 0;
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_idle_pct = 0;
  logic [TS_W-1:0]   clock_ms;

  frame_rate_meter_limiter_unit #(.WINDOW_SIZE(WINDOW)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // timestamp_ms
    .s_axis_tuser  (s_axis_tuser),   // action
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // frame_time_ms, fps_q8, delay_ms, zero pad
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic reset_meter();
    cap_reg     = MAX_FPS_RESET;
    frame_start = '0;
    last_end    = '0;
    seen_end    = 1'b0;
    ring_slot   = 0;
    ring_count  = 0;
    ring_total  = 0;
    foreach (frame_ring[i]) frame_ring[i] = '0;
  endtask

  task automatic predict_frame(input logic act, input logic [TS_W-1:0] ts);
    logic [TS_W-1:0]  diff;
    logic [FT_W-1:0]  dt;
    logic [63:0]      rate;
    int unsigned      cap;
    int unsigned      period;
    logic [TS_W-1:0]  elapsed;
    frame_result_t    res;
    if (act == ACT_BEGIN) begin
      frame_start = ts;
      return;
    end
    if (seen_end) begin
      diff = ts - last_end;
      dt   = (diff > TS_W'(FT_SAT)) ? FT_SAT : diff[FT_W-1:0];
    end else begin
      dt = '0;
    end
    last_end = ts;
    seen_end = 1'b1;
    if (ring_count == WINDOW) ring_total -= frame_ring[ring_slot];
    else ring_count++;
    frame_ring[ring_slot] = dt;
    ring_total += dt;
    ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
    if (ring_total == 0) begin
      res.fps = FPS_DEFAULT_Q8;
    end else begin
      rate    = (64'(FPS_SCALE) * ring_count) / ring_total;
      res.fps = (rate > 64'(FPS_MAX_Q8)) ? FPS_MAX_Q8 : rate[FPS_W-1:0];
    end
    cap       = (cap_reg == '0) ? 1 : cap_reg;
    period    = PERIOD_NUM / cap;
    elapsed   = ts - frame_start;
    res.delay = (elapsed < period) ? DELAY_W'(period - elapsed) : '0;
    res.frame_time = dt;
    pending_results.push_back(res);
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    frame_result_t want;
    frame_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.frame_time = m_axis_tdata[FT_W-1:0];
      got.fps        = m_axis_tdata[FT_W+FPS_W-1:FT_W];
      got.delay      = m_axis_tdata[FT_W+FPS_W+DELAY_W-1:FT_W+FPS_W];
      if (pending_results.size() == 0) begin
        $error("unexpected result: frame_time_ms %0d fps_q8 %0d delay_ms %0d",
               got.frame_time, got.fps, got.delay);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.frame_time !== want.frame_time) begin
          $error("frame_time_ms: expected %0d, got %0d", want.frame_time, got.frame_time);
          err_cnt++;
        end
        if (got.fps !== want.fps) begin
          $error("fps_q8: expected %0d, got %0d", want.fps, got.fps);
          err_cnt++;
        end
        if (got.delay !== want.delay) begin
          $error("delay_ms: expected %0d, got %0d", want.delay, got.delay);
          err_cnt++;
        end
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_event(input logic act, input logic [TS_W-1:0] ts);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= ts;
    do begin
      @(posedge clk_i);
      taken = s_axis_tvalid && s_axis_tready;
      if (taken) predict_frame(act, ts);
      @(negedge clk_i);
    end while (!taken);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_cap(input logic [CAP_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_FPS, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cap_reg = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_first_frames();
    send_event(ACT_END, 32'd100);
    send_event(ACT_END, 32'd100);
    send_event(ACT_END, 32'd101);
    send_event(ACT_BEGIN, 32'd110);
    send_event(ACT_END, 32'd116);
    send_event(ACT_BEGIN, 32'd116);
    send_event(ACT_END, 32'd116);
    send_event(ACT_BEGIN, 32'hFFFF_FFF0);
    send_event(ACT_END, 32'h0000_0005);
    send_event(ACT_END, 32'h0001_0010);
    for (int k = 1; k <= 6; k++) send_event(ACT_END, 32'h0001_0010 + k);
    send_event(ACT_BEGIN, 32'hFFFF_FFFF);
    send_event(ACT_END, 32'hFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_rate_cap();
    logic [CAP_W-1:0] caps [4];
    logic [TS_W-1:0]  t0;
    caps = '{10'd1, 10'd1000, 10'd0, 10'd1023};
    foreach (caps[i]) begin
      write_cap(caps[i]);
      t0 = $urandom;
      send_event(ACT_BEGIN, t0);
      send_event(ACT_END, t0 + $urandom_range(0, 2));
      wait_idle();
    end
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned tx_pct,
                                     input int unsigned rx_pct, input logic [CAP_W-1:0] cap);
    int unsigned     sent;
    int unsigned     pick;
    logic [TS_W-1:0] dur;
    write_cap(cap);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        pick = $urandom_range(99);
        if (pick < 60)      dur = $urandom_range(0, 40);
        else if (pick < 85) dur = $urandom_range(0, 1100);
        else if (pick < 95) dur = $urandom_range(65000, 70000);
        else                dur = $urandom;
        send_event(ACT_BEGIN, clock_ms);
        clock_ms += dur;
        send_event(ACT_END, clock_ms);
        clock_ms += $urandom_range(0, 3);
        sent += 2;
      end else if (pick < 88) begin
        clock_ms += $urandom_range(0, 50);
        send_event(ACT_END, clock_ms);
        sent++;
      end else if (pick < 94) begin
        clock_ms += $urandom_range(0, 50);
        send_event(ACT_BEGIN, clock_ms);
        sent++;
      end else if (pick < 97) begin
        clock_ms = $urandom;
        send_event(1'($urandom_range(1)), clock_ms);
        sent++;
      end else begin
        // run up to the timestamp wrap
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
      end
    end
    wait_idle();
  endtask

  initial begin
    reset_meter();
    clock_ms = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_first_frames();
    test_rate_cap();
    test_random_traffic(280, 33, 82, 10'd60);
    test_random_traffic(280, 82, 33, 10'($urandom_range(1, 1000)));
    test_random_traffic(290, 0, 0, 10'($urandom_range(1, 200)));
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
